// ----- hw/rtl/dmwt_pkg.sv -----
package dmwt_pkg;

   localparam int ADDR_BITS   = 32;
   localparam int OFFSET_BITS = 5;
   localparam int INDEX_BITS  = 7;
   localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
   localparam int NUM_LINES   = 1 << INDEX_BITS;
   localparam int COUNT_BITS  = 32;

   // response payload: offset, index, tag, four flags, evicted tag, two totals
   localparam int RSP_DATA_BITS = OFFSET_BITS + INDEX_BITS + TAG_BITS + 4 + TAG_BITS
                                  + 2 * COUNT_BITS;

   typedef logic [ADDR_BITS-1:0]     addr_type;
   typedef logic [OFFSET_BITS-1:0]   offset_type;
   typedef logic [INDEX_BITS-1:0]    index_type;
   typedef logic [TAG_BITS-1:0]      tag_type;
   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [RSP_DATA_BITS-1:0] rsp_data_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;  // latch request, read tag and valid of its line
      logic resolve;  // compare, update line and counters, load response
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic fetch;    // the request under resolution is a read miss
   } status_type;

endpackage

// ----- hw/rtl/direct_mapped_write_through_tags.sv -----
// Flow: a request is latched in IDLE, which also starts the registered read of the tag
//   store, and its response is loaded in RESOLVE as soon as the response register is
//   free; it waits there while the previous response is still held by the consumer.
//   A new request is taken only after the current one is resolved, as the tag read is
//   followed by the compare-and-update step on the same line.
// Reset: synchronous, active high; clears all valid bits, both counters and the
//   handshake state. The tag store itself is not cleared.
module direct_mapped_write_through_tags (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dmwt_pkg::ADDR_BITS-1:0] req_tdata,  // [31:0] address
   input  logic                          req_tuser,   // [0] is_write
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [4:0] byte_offset, [11:5] line_index, [31:12] address_tag, [32] miss,
   // [33] fetch_line, [34] write_memory, [35] replaced, [55:36] evicted_tag,
   // [87:56] hit_total, [119:88] miss_total
   output logic [dmwt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import dmwt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller: IDLE takes a request, RESOLVE waits for the response register
   // to be free, then commits the lookup. The response register stays
   // independent, so a new request is taken while a response is held.
   dmwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: tag memory (registered read), valid flops, saturating hit and
   // miss counters, and the response register. A read miss installs the tag
   // and sets valid; writes go through and never allocate.
   dmwt_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_address  (req_tdata),
      .req_is_write (req_tuser),
      .rsp_data     (rsp_tdata)
   );

endmodule

// ----- hw/rtl/dmwt_ctrl.sv -----
module dmwt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  dmwt_pkg::status_type status,
   output dmwt_pkg::cmd_type    cmd
);
   import dmwt_pkg::*;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RESOLVE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      fetch_seen_ff, fetch_seen_in;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign cmd.capture = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.resolve = (state_ff == ST_RESOLVE) && out_free;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      fetch_seen_in = fetch_seen_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               fetch_seen_in = status.fetch;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         fetch_seen_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         fetch_seen_ff <= fetch_seen_in;
      end
   end

   // last resolved request was a line fill
   logic unused_fetch;
   assign unused_fetch = fetch_seen_ff;

endmodule

// ----- hw/rtl/dmwt_datapath.sv -----
module dmwt_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  dmwt_pkg::cmd_type      cmd,
   output dmwt_pkg::status_type   status,
   input  dmwt_pkg::addr_type     req_address,
   input  logic                   req_is_write,
   output dmwt_pkg::rsp_data_type rsp_data
);
   import dmwt_pkg::*;

   tag_type   tag_mem [NUM_LINES];
   logic      [NUM_LINES-1:0] valid_ff, valid_in;

   addr_type  addr_ff;
   logic      wr_ff;
   tag_type   tag_rd_ff;
   logic      valid_rd_ff;
   count_type hit_ff, hit_in;
   count_type miss_cnt_ff, miss_cnt_in;
   rsp_data_type rsp_ff, rsp_in;

   offset_type offset;
   index_type  index;
   tag_type    tag;
   index_type  req_index;
   logic       miss, fetch, repl;
   tag_type    evicted;

   assign req_index = req_address[OFFSET_BITS +: INDEX_BITS];
   assign offset    = addr_ff[OFFSET_BITS-1:0];
   assign index     = addr_ff[OFFSET_BITS +: INDEX_BITS];
   assign tag       = addr_ff[ADDR_BITS-1 -: TAG_BITS];

   assign miss    = !(valid_rd_ff && (tag_rd_ff == tag));
   assign fetch   = !wr_ff && miss;
   assign repl    = fetch && valid_rd_ff;
   assign evicted = repl ? tag_rd_ff : '0;

   assign status.fetch = fetch;

   always_comb begin
      valid_in    = valid_ff;
      hit_in      = hit_ff;
      miss_cnt_in = miss_cnt_ff;
      if (cmd.resolve) begin
         if (fetch) begin
            valid_in[index] = 1'b1;
         end
         if (miss) begin
            if (miss_cnt_ff != '1) begin
               miss_cnt_in = miss_cnt_ff + 1'b1;
            end
         end else if (hit_ff != '1) begin
            hit_in = hit_ff + 1'b1;
         end
      end
      rsp_in = {miss_cnt_in, hit_in, evicted, repl, wr_ff, fetch, miss, tag, index, offset};
   end

   // tag store: read at capture, written on a line fill
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tag_rd_ff <= tag_mem[req_index];
      end
      if (cmd.resolve && fetch) begin
         tag_mem[index] <= tag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff     <= req_address;
         wr_ff       <= req_is_write;
         valid_rd_ff <= valid_ff[req_index];
      end
      if (cmd.resolve) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         hit_ff      <= '0;
         miss_cnt_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         hit_ff      <= hit_in;
         miss_cnt_ff <= miss_cnt_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- hw/rtl/dmwt_checker.sv -----
module dmwt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [dmwt_pkg::ADDR_BITS-1:0]     req_tdata,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [dmwt_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import dmwt_pkg::*;

   logic unused_in;
   assign unused_in = ^{req_tdata, req_tuser};

   // held response must not drop
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one request in flight: ready drops after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in flight");

   // line fill only on a read miss; replacement only on a fill
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[33] || (rsp_tdata[32] && !rsp_tdata[34]))
                     && (!rsp_tdata[35] || rsp_tdata[33]))
      else $error("inconsistent miss/fetch/replace flags");

   // evicted tag is zero unless a line was replaced
   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[35] |-> rsp_tdata[55:36] == '0)
      else $error("evicted tag without replacement");

endmodule

bind direct_mapped_write_through_tags dmwt_checker u_dmwt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/tb_top.sv -----
module tb_top;
   import dmwt_pkg::*;

   // read/write flag carried in req_tuser
   localparam logic ACCESS_READ  = 1'b0;
   localparam logic ACCESS_WRITE = 1'b1;

   localparam int RANDOM_ACCESSES = 1335;
   localparam int TAIL_ACCESSES   = 150;  // no idling once this few are left
   localparam int HOLD_START      = 150;  // cycles after reset when the long stall begins
   localparam int HOLD_CYCLES     = 120;
   localparam int MAX_REPORTS     = 10;

   // response fields, lowest bits last
   typedef struct packed {
      count_type  miss_total;
      count_type  hit_total;
      tag_type    evicted_tag;
      logic       replaced;
      logic       write_memory;
      logic       fetch_line;
      logic       miss;
      tag_type    address_tag;
      index_type  line_index;
      offset_type byte_offset;
   } rsp_fields_type;

   typedef struct {
      addr_type address;
      logic     is_write;
   } access_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ADDR_BITS-1:0]     req_tdata  = '0;   // [31:0] address
   logic                     req_tuser  = 1'b0; // [0] is_write
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;         // fields as in rsp_fields_type

   direct_mapped_write_through_tags DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Cache mirror: tags, valid bits and the two saturating tallies
   // ------------------------------------------------------------------
   tag_type              tag_mirror [NUM_LINES];
   bit [NUM_LINES-1:0]   line_valid = '0;
   count_type            hit_tally  = '0;
   count_type            miss_tally = '0;

   access_type           pending_accesses [$];
   rsp_fields_type       expected_responses [$];

   int                   pushed_total  = 0;  // expectations queued, updated by the driver
   int                   popped_total  = 0;  // responses taken, updated by the monitor
   int                   mismatch_count = 0;
   int                   gap_left      = 0;
   int                   stall_left    = 0;
   int                   hold_left     = 0;
   int                   cycles_up     = 0;
   logic                 quiet_tail    = 1'b0;

   // Looks up one access, updates the mirror and returns the response it yields.
   function automatic rsp_fields_type predict_access(input addr_type address,
                                                     input logic is_write);
      rsp_fields_type r;
      index_type      idx;
      tag_type        tg;
      logic           hit;
      idx = address[OFFSET_BITS +: INDEX_BITS];
      tg  = address[ADDR_BITS-1 -: TAG_BITS];
      hit = line_valid[idx] && (tag_mirror[idx] == tg);
      r = '0;
      r.byte_offset  = address[OFFSET_BITS-1:0];
      r.line_index   = idx;
      r.address_tag  = tg;
      r.miss         = !hit;
      r.write_memory = is_write;
      // only a read miss allocates; writes go straight through
      r.fetch_line   = (is_write == ACCESS_READ) && !hit;
      r.replaced     = r.fetch_line && line_valid[idx];
      if (r.replaced)
         r.evicted_tag = tag_mirror[idx];
      if (r.fetch_line) begin
         line_valid[idx] = 1'b1;
         tag_mirror[idx] = tg;
      end
      if (hit) begin
         if (hit_tally != '1)
            hit_tally = hit_tally + 1'b1;
      end else begin
         if (miss_tally != '1)
            miss_tally = miss_tally + 1'b1;
      end
      r.hit_total  = hit_tally;
      r.miss_total = miss_tally;
      return r;
   endfunction

   task automatic add_access(input addr_type address, input logic is_write);
      access_type a;
      a.address  = address;
      a.is_write = is_write;
      pending_accesses.push_back(a);
   endtask

   task automatic check_field(input string field_name, input logic [31:0] want,
                              input logic [31:0] seen);
      if (seen !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("response %0d: %s expected 0x%0h, got 0x%0h",
                     popped_total, field_name, want, seen);
      end
   endtask

   // ------------------------------------------------------------------
   // Request driver: offers queued accesses, idles in random bursts.
   // An accepted request is predicted at the edge that accepts it.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      access_type next_access;
      logic       offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_responses.push_back(predict_access(req_tdata, req_tuser));
            pushed_total <= pushed_total + 1;
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
               gap_left <= $urandom_range(1, 10) - 1;  // this cycle is the first idle one
            end else if (pending_accesses.size() > 0) begin
               next_access = pending_accesses.pop_front();
               req_tdata <= next_access.address;
               req_tuser <= next_access.is_write;
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
         quiet_tail <= pending_accesses.size() < TAIL_ACCESSES;
      end
   end

   // ------------------------------------------------------------------
   // Response side backpressure: one long hold early on so the request
   // side backs up, then random stall bursts until the tail.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
         cycles_up  <= 0;
      end else begin
         cycles_up <= cycles_up + 1;
         if (cycles_up == HOLD_START) begin
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(1, 10) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: each response against the oldest expectation.
   // pushed_total is sampled before this edge's update, so an
   // expectation counted here is already in the queue.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_fields_type seen;
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_fields_type'(rsp_tdata);
         if (popped_total >= pushed_total) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("response with no request pending: 0x%0h", rsp_tdata);
         end else begin
            want = expected_responses.pop_front();
            check_field("byte_offset",  32'(want.byte_offset),  32'(seen.byte_offset));
            check_field("line_index",   32'(want.line_index),   32'(seen.line_index));
            check_field("address_tag",  32'(want.address_tag),  32'(seen.address_tag));
            check_field("miss",         32'(want.miss),         32'(seen.miss));
            check_field("fetch_line",   32'(want.fetch_line),   32'(seen.fetch_line));
            check_field("write_memory", 32'(want.write_memory), 32'(seen.write_memory));
            check_field("replaced",     32'(want.replaced),     32'(seen.replaced));
            check_field("evicted_tag",  32'(want.evicted_tag),  32'(seen.evicted_tag));
            check_field("hit_total",    want.hit_total,         seen.hit_total);
            check_field("miss_total",   want.miss_total,        seen.miss_total);
            popped_total <= popped_total + 1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      tag_type   tag_pool [4];
      index_type hot_lines [8];
      index_type idx;
      addr_type  address;
      int        pick;

      for (int k = 0; k < NUM_LINES; k++)
         tag_mirror[k] = '0;

      // directed: line 0 and line 127 at the address extremes
      add_access(32'h0000_0000, ACCESS_READ);   // read miss, invalid line
      add_access(32'h0000_001F, ACCESS_READ);   // hit, top byte of the line
      add_access(32'h0000_0004, ACCESS_WRITE);  // write hit
      add_access(32'hFFFF_FFFF, ACCESS_WRITE);  // write miss, invalid line: no allocate
      add_access(32'hFFFF_FFE0, ACCESS_READ);   // read miss, still invalid
      add_access(32'hFFFF_FFFF, ACCESS_READ);   // hit on all-ones tag
      add_access(32'h1234_5FE0, ACCESS_WRITE);  // write miss on a valid line
      add_access(32'hFFFF_FFF0, ACCESS_READ);   // still a hit, write did not allocate
      add_access(32'h0000_0FE0, ACCESS_READ);   // replace, evicts all-ones tag
      add_access(32'hFFFF_FFE0, ACCESS_READ);   // replace, evicts zero tag
      // consecutive accesses to one line
      add_access(32'hABCD_E020, ACCESS_READ);
      add_access(32'hABCD_E03F, ACCESS_READ);
      add_access(32'h5432_1020, ACCESS_READ);
      add_access(32'hABCD_E020, ACCESS_READ);
      add_access(32'hABCD_E021, ACCESS_WRITE);
      add_access(32'hABCD_E022, ACCESS_READ);
      add_access(32'h5432_103C, ACCESS_WRITE);
      add_access(32'h5432_103D, ACCESS_READ);

      // random: a few tags over a handful of hot lines, so hits, replacements
      // and same-line runs are common; some fully random addresses as noise
      foreach (tag_pool[k])
         tag_pool[k] = tag_type'($urandom);
      foreach (hot_lines[k])
         hot_lines[k] = index_type'($urandom);
      repeat (RANDOM_ACCESSES) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            address = $urandom;
         end else begin
            idx = (pick < 30) ? index_type'($urandom) : hot_lines[$urandom_range(0, 7)];
            address = {tag_pool[$urandom_range(0, 3)], idx, offset_type'($urandom)};
         end
         add_access(address, ($urandom_range(0, 99) < 30) ? ACCESS_WRITE : ACCESS_READ);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_accesses.size() != 0 || req_tvalid);
      do @(posedge clock);
      while (popped_total != pushed_total);
      // catch any stray response after the last one
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/dmwt_pkg.sv
hw/rtl/dmwt_ctrl.sv
hw/rtl/dmwt_datapath.sv
hw/rtl/direct_mapped_write_through_tags.sv
hw/rtl/dmwt_checker.sv
bench/tb_top.sv
